### rtl/mesl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesl_pkg - shared types and constants
// Register map, configuration bundle and widths for the motion enable
// switch logic.
// ----------------------------------------------------------------------------
package mesl_pkg;

	localparam int CntW   = 16;
	localparam int DataW  = 32;
	localparam int AddrW  = 3;

	// register indexes (byte address = 4 * index)
	typedef enum logic [0:0] {
		REG_COOLDOWN   = 1'b0,
		REG_START_HOLD = 1'b1
	} mesl_reg_t;

	localparam logic [CntW-1:0] CooldownReset  = 16'd1000;
	localparam logic [CntW-1:0] StartHoldReset = 16'd500;

	typedef struct packed {
		logic [CntW-1:0] cooldown_ticks;
		logic [CntW-1:0] start_hold_ticks;
	} mesl_cfg_t;

endpackage

### rtl/mesl_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesl_in_if - input item channel
// Valid/ready channel carrying one control tick of switch and request levels.
// ----------------------------------------------------------------------------
interface mesl_in_if;
	logic valid;
	logic ready;
	logic switch_pressed;
	logic switch_panic;
	logic motion_active;
	logic extra_enable;
	logic extra_disable;

	modport source (
		output valid, switch_pressed, switch_panic, motion_active,
		       extra_enable, extra_disable,
		input  ready
	);
	modport sink (
		input  valid, switch_pressed, switch_panic, motion_active,
		       extra_enable, extra_disable,
		output ready
	);
endinterface

### rtl/mesl_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesl_out_if - result channel
// Valid/ready channel carrying the stop and enable commands of one tick.
// ----------------------------------------------------------------------------
interface mesl_out_if;
	logic valid;
	logic ready;
	logic soft_stop;
	logic enable_motion;

	modport source (
		output valid, soft_stop, enable_motion,
		input  ready
	);
	modport sink (
		input  valid, soft_stop, enable_motion,
		output ready
	);
endinterface

### rtl/mesl_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesl_cfg_regs - configuration registers
// APB-style write/read of the cooldown and start-hold tick counts.
// ----------------------------------------------------------------------------
module mesl_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mesl_pkg::AddrW-1:0]  paddr,
	input  logic [mesl_pkg::DataW-1:0]  pwdata,
	output logic [mesl_pkg::DataW-1:0]  prdata,
	output logic                        pready,
	output mesl_pkg::mesl_cfg_t         cfg
);
	import mesl_pkg::*;

	logic [CntW-1:0] cooldown_q;
	logic [CntW-1:0] start_hold_q;
	logic            wr_en;
	mesl_reg_t       reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	// word index; low byte-offset bits are ignored
	assign reg_sel = mesl_reg_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q   <= CooldownReset;
			start_hold_q <= StartHoldReset;
		end else if (wr_en) begin
			case (reg_sel)
				REG_COOLDOWN:   cooldown_q   <= pwdata[CntW-1:0];
				REG_START_HOLD: start_hold_q <= pwdata[CntW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_COOLDOWN:   prdata = {{(DataW-CntW){1'b0}}, cooldown_q};
			REG_START_HOLD: prdata = {{(DataW-CntW){1'b0}}, start_hold_q};
			default:        prdata = '0;
		endcase
	end

	assign cfg.cooldown_ticks   = cooldown_q;
	assign cfg.start_hold_ticks = start_hold_q;

endmodule

### rtl/mesl_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesl_core - decision logic and tick state
// Edge detects, cooldown lockout and hold-to-start counters; computes the
// stop/enable commands of a tick and advances state when the tick transfers.
// ----------------------------------------------------------------------------
module mesl_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                tick,
	input  logic                switch_pressed,
	input  logic                switch_panic,
	input  logic                motion_active,
	input  logic                extra_enable,
	input  logic                extra_disable,
	input  mesl_pkg::mesl_cfg_t cfg,
	output logic                soft_stop,
	output logic                enable_motion
);
	import mesl_pkg::*;

	logic            prev_pressed_q;
	logic            prev_panic_q;
	logic            prev_active_q;
	logic            prev_ext_en_q;
	logic [CntW-1:0] hold_q;
	logic [CntW-1:0] cooldown_q;

	logic [CntW-1:0] hold_d;
	logic [CntW-1:0] cooldown_d;
	logic            stop;
	logic            enable;
	logic            changed;

	assign changed = (switch_pressed != prev_pressed_q) || (switch_panic != prev_panic_q);

	always_comb begin
		hold_d     = hold_q;
		cooldown_d = cooldown_q;
		stop       = 1'b0;
		enable     = 1'b0;
		if (cooldown_q != '0) begin
			cooldown_d = cooldown_q - 1'b1;
			hold_d     = '0;
		end else if ((prev_active_q && !motion_active) || switch_panic) begin
			hold_d     = '0;
			cooldown_d = cfg.cooldown_ticks;
			stop       = 1'b1;
		end else if (changed && switch_pressed) begin
			if (!motion_active) begin
				hold_d = cfg.start_hold_ticks;
			end else begin
				stop       = 1'b1;
				hold_d     = '0;
				cooldown_d = cfg.cooldown_ticks;
			end
		end else if (!switch_pressed) begin
			hold_d = '0;
		end else if (hold_q != '0) begin
			hold_d = hold_q - 1'b1;
			enable = (hold_q == CntW'(1));
		end
		if (extra_enable && !prev_ext_en_q) begin
			enable = 1'b1;
		end
		if (extra_disable) begin
			stop = 1'b1;
		end
	end

	assign soft_stop     = stop;
	assign enable_motion = enable && !stop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_pressed_q <= 1'b0;
			prev_panic_q   <= 1'b0;
			prev_active_q  <= 1'b0;
			prev_ext_en_q  <= 1'b0;
			hold_q         <= '0;
			cooldown_q     <= '0;
		end else if (tick) begin
			prev_pressed_q <= switch_pressed;
			prev_panic_q   <= switch_panic;
			prev_active_q  <= motion_active;
			prev_ext_en_q  <= extra_enable;
			hold_q         <= hold_d;
			cooldown_q     <= cooldown_d;
		end
	end

endmodule

### rtl/motion_enable_switch_logic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_enable_switch_logic - enabling switch to stop/enable commands
// Turns enabling switch, motion status and external request levels into
// soft stop and motion enable commands with cooldown and hold-to-start.
// ----------------------------------------------------------------------------
// Usage:
//   item   : one control tick per transfer (switch_pressed, switch_panic,
//            motion_active, extra_enable, extra_disable).
//   result : exactly one transfer per item (soft_stop, enable_motion); the
//            two are never both high.
//   APB    : register 0 at 0x0 = cooldown_ticks (reset 1000), register 1
//            at 0x4 = start_hold_ticks (reset 500), low 16 bits kept.
//            Write only while no item is in flight.
// Latency: the result is valid the cycle after the item transfers.
// Throughput: one item per cycle; the decision logic is a single pass of
//   edge detects, two 16-bit decrements and a priority select, registered
//   into one output stage.
// Stall: item.ready follows "output stage empty or being taken", so a
//   stalled receiver holds the result and blocks new items; nothing is lost.
// Reset: arst_n clears edge history, counters and the output valid; config
//   returns to its reset values. No clearing pass.
// ----------------------------------------------------------------------------
module motion_enable_switch_logic (
	input  logic                        clk,
	input  logic                        arst_n,
	mesl_in_if.sink                     item,
	mesl_out_if.source                  result,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mesl_pkg::AddrW-1:0]  paddr,
	input  logic [mesl_pkg::DataW-1:0]  pwdata,
	output logic [mesl_pkg::DataW-1:0]  prdata,
	output logic                        pready
);
	import mesl_pkg::*;

	mesl_cfg_t cfg;
	logic      tick;
	logic      stop_c;
	logic      enable_c;
	logic      valid_q;
	logic      soft_stop_q;
	logic      enable_motion_q;

	mesl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// accept whenever the output stage is free or drains this cycle
	assign item.ready = !valid_q || result.ready;
	assign tick       = item.valid && item.ready;

	mesl_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.tick           (tick),
		.switch_pressed (item.switch_pressed),
		.switch_panic   (item.switch_panic),
		.motion_active  (item.motion_active),
		.extra_enable   (item.extra_enable),
		.extra_disable  (item.extra_disable),
		.cfg            (cfg),
		.soft_stop      (stop_c),
		.enable_motion  (enable_c)
	);

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (tick) begin
			valid_q <= 1'b1;
		end else if (result.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tick) begin
			soft_stop_q     <= stop_c;
			enable_motion_q <= enable_c;
		end
	end

	assign result.valid         = valid_q;
	assign result.soft_stop     = soft_stop_q;
	assign result.enable_motion = enable_motion_q;

	// every accepted tick produces a result next cycle
	a_tick_result: assert property (@(posedge clk) disable iff (!arst_n)
		tick |=> result.valid)
		else $error("accepted item produced no result");

	// stop outranks enable
	a_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> !(result.soft_stop && result.enable_motion))
		else $error("soft_stop and enable_motion both set");

	// external disable always yields a stop
	a_ext_disable: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && item.extra_disable) |=> (result.valid && result.soft_stop))
		else $error("extra_disable did not command a stop");

endmodule

### dv/mesl_cmd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mesl_cmd_checker - command predictor and scoreboard
// Watches the tick and command channels and the APB port, keeps its own copy
// of the switch logic state and registers, and compares every command
// transfer against the oldest predicted command.
// ----------------------------------------------------------------------------
module mesl_cmd_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	mesl_in_if                          tick_ch,
	mesl_out_if                         cmd_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mesl_pkg::AddrW-1:0]  paddr,
	input  logic [mesl_pkg::DataW-1:0]  pwdata,
	input  logic [mesl_pkg::DataW-1:0]  prdata,
	input  logic                        pready,
	output int                          errors,
	output int                          outstanding
);
	import mesl_pkg::*;

	typedef struct packed {
		logic pressed;
		logic panic;
		logic active;
		logic ext_en;
		logic ext_dis;
	} tick_t;

	typedef struct packed {
		logic stop;
		logic enable;
	} cmd_t;

	mesl_cfg_t       cfg;
	logic            last_pressed, last_panic, last_active, last_ext_en;
	logic [CntW-1:0] hold_left;
	logic [CntW-1:0] lockout_left;
	cmd_t            cmd_due[$];

	initial begin
		errors = 0;
		outstanding = 0;
	end

	task automatic flag(input string msg);
		$display("%0t ns: MISMATCH %s", $time, msg);
		errors++;
	endtask

	// one control tick of the switch logic; updates the shadow state
	function automatic cmd_t decide_cmd(input tick_t t);
		cmd_t c;
		logic moved;
		c = '0;
		moved = (t.pressed != last_pressed) || (t.panic != last_panic);
		if (lockout_left != 0) begin
			lockout_left--;
			hold_left = '0;
		end else if ((last_active && !t.active) || t.panic) begin
			hold_left = '0;
			lockout_left = cfg.cooldown_ticks;
			c.stop = 1'b1;
		end else if (moved && t.pressed) begin
			if (!t.active) begin
				hold_left = cfg.start_hold_ticks;
			end else begin
				c.stop = 1'b1;
				hold_left = '0;
				lockout_left = cfg.cooldown_ticks;
			end
		end else if (!t.pressed) begin
			hold_left = '0;
		end else if (hold_left != 0) begin
			hold_left--;
			if (hold_left == 0)
				c.enable = 1'b1;
		end
		if (t.ext_en && !last_ext_en)
			c.enable = 1'b1;
		if (t.ext_dis)
			c.stop = 1'b1;
		if (c.stop)
			c.enable = 1'b0;
		last_pressed = t.pressed;
		last_panic = t.panic;
		last_active = t.active;
		last_ext_en = t.ext_en;
		return c;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		tick_t t;
		cmd_t want;
		logic [CntW-1:0] reg_val;
		if (!arst_n) begin
			cfg.cooldown_ticks = CooldownReset;
			cfg.start_hold_ticks = StartHoldReset;
			last_pressed = 1'b0;
			last_panic = 1'b0;
			last_active = 1'b0;
			last_ext_en = 1'b0;
			hold_left = '0;
			lockout_left = '0;
		end else begin
			// register access
			if (psel && penable && pready) begin
				case (mesl_reg_t'(paddr[AddrW-1:2]))
					REG_COOLDOWN: reg_val = cfg.cooldown_ticks;
					default: reg_val = cfg.start_hold_ticks;
				endcase
				if (pwrite) begin
					case (mesl_reg_t'(paddr[AddrW-1:2]))
						REG_COOLDOWN: cfg.cooldown_ticks = pwdata[CntW-1:0];
						REG_START_HOLD: cfg.start_hold_ticks = pwdata[CntW-1:0];
						default: ;
					endcase
				end else if (prdata[CntW-1:0] !== reg_val) begin
					flag($sformatf("read addr %0h: got %0h, want %0h",
						paddr, prdata[CntW-1:0], reg_val));
				end
			end
			// command transfer: compare against the oldest prediction
			if (cmd_ch.valid && cmd_ch.ready) begin
				if (cmd_due.size() == 0) begin
					flag("command transfer with nothing predicted");
				end else begin
					want = cmd_due.pop_front();
					if (cmd_ch.soft_stop !== want.stop)
						flag($sformatf("soft_stop: got %b, want %b",
							cmd_ch.soft_stop, want.stop));
					if (cmd_ch.enable_motion !== want.enable)
						flag($sformatf("enable_motion: got %b, want %b",
							cmd_ch.enable_motion, want.enable));
				end
			end
			// tick transfer: predict its command
			if (tick_ch.valid && tick_ch.ready) begin
				t.pressed = tick_ch.switch_pressed;
				t.panic = tick_ch.switch_panic;
				t.active = tick_ch.motion_active;
				t.ext_en = tick_ch.extra_enable;
				t.ext_dis = tick_ch.extra_disable;
				cmd_due.push_back(decide_cmd(t));
			end
		end
		outstanding = cmd_due.size();
	end

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - motion enable switch logic testbench
// Drives control ticks and APB register writes into the block, with random
// gaps on the tick side and random stalls on the command side. A checker
// beside the block predicts every command and counts mismatches.
// ----------------------------------------------------------------------------
module tb;
	import mesl_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             psel;
	logic             penable;
	logic             pwrite;
	logic [AddrW-1:0] paddr;
	logic [DataW-1:0] pwdata;
	logic [DataW-1:0] prdata;
	logic             pready;
	int               errors;
	int               outstanding;

	// calm: no gaps and no stalls; squeeze_cnt: bump to ask for a long hold-off
	logic             calm;
	int               squeeze_cnt;

	mesl_in_if  tick_ch();
	mesl_out_if cmd_ch();

	motion_enable_switch_logic dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (tick_ch),
		.result  (cmd_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mesl_cmd_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick_ch     (tick_ch),
		.cmd_ch      (cmd_ch),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// gap length: mostly short, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(10, 35);
	endfunction

	// command side: random stalls, plus a long hold-off on request so the
	// output stage fills and the block backs up its tick input
	initial begin
		int stall;
		int squeeze_seen;
		stall = 0;
		squeeze_seen = 0;
		cmd_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze_cnt != squeeze_seen) begin
				squeeze_seen = squeeze_cnt;
				stall = 80;
			end
			if (stall > 0) begin
				cmd_ch.ready <= 1'b0;
				stall--;
			end else if (calm || $urandom_range(0, 9) >= 2) begin
				cmd_ch.ready <= 1'b1;
			end else begin
				cmd_ch.ready <= 1'b0;
				stall = pick_gap() - 1;
			end
		end
	end

	// one tick transfer; called right after the previous transfer's edge
	task automatic send_tick(input logic p, input logic pn, input logic a,
				 input logic en, input logic dis);
		int gap;
		gap = (calm || $urandom_range(0, 9) >= 3) ? 0 : pick_gap();
		@(negedge clk);
		if (gap != 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		tick_ch.valid          <= 1'b1;
		tick_ch.switch_pressed <= p;
		tick_ch.switch_panic   <= pn;
		tick_ch.motion_active  <= a;
		tick_ch.extra_enable   <= en;
		tick_ch.extra_disable  <= dis;
		@(posedge clk);
		while (!tick_ch.ready) @(posedge clk);
	endtask

	// APB write; upper data bits carry junk the block must drop
	task automatic reg_write(input mesl_reg_t idx, input logic [CntW-1:0] val);
		logic [DataW-1:0] word;
		word = $urandom;
		word[CntW-1:0] = val;
		@(negedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b1;
		paddr  <= {idx, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// APB read; the checker compares prdata at the access edge
	task automatic reg_read(input mesl_reg_t idx);
		@(negedge clk);
		psel   <= 1'b1;
		pwrite <= 1'b0;
		paddr  <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// stop offering ticks, wait for every command, then let the pipe settle
	task automatic drain();
		@(negedge clk);
		tick_ch.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic set_regs(input logic [CntW-1:0] cool, input logic [CntW-1:0] hold);
		reg_write(REG_COOLDOWN, cool);
		reg_write(REG_START_HOLD, hold);
		reg_read(REG_COOLDOWN);
		reg_read(REG_START_HOLD);
	endtask

	// Operator-like traffic: press runs sized around the hold time so the
	// timer both expires and gets cancelled, slowly changing motion status
	// and external enable, rare panic and disable. About one tick in eight
	// is plain noise.
	task automatic random_phase(input int n, input int hl);
		int run_left;
		logic p, a, en;
		logic [4:0] r;
		run_left = 0;
		p = 1'b0;
		a = 1'b0;
		en = 1'b0;
		repeat (n) begin
			if ($urandom_range(0, 99) < 12) begin
				r = 5'($urandom);
				send_tick(r[0], r[1], r[2], r[3], r[4]);
			end else begin
				if (run_left == 0) begin
					p = ~p;
					if (!p)
						run_left = $urandom_range(1, 5);
					else if ($urandom_range(0, 2) != 0)
						run_left = hl + $urandom_range(1, 3);
					else
						run_left = $urandom_range(1, hl + 1);
				end
				run_left--;
				if ($urandom_range(0, 99) < 8)
					a = ~a;
				if ($urandom_range(0, 99) < 10)
					en = ~en;
				send_tick(p, $urandom_range(0, 99) < 3, a, en,
					$urandom_range(0, 99) < 3);
			end
		end
	endtask

	initial begin
		logic [CntW-1:0] cool, hold;
		arst_n               = 1'b0;
		calm                 = 1'b0;
		squeeze_cnt          = 0;
		psel                 <= 1'b0;
		penable              <= 1'b0;
		pwrite               <= 1'b0;
		paddr                <= '0;
		pwdata               <= '0;
		tick_ch.valid          <= 1'b0;
		tick_ch.switch_pressed <= 1'b0;
		tick_ch.switch_panic   <= 1'b0;
		tick_ch.motion_active  <= 1'b0;
		tick_ch.extra_enable   <= 1'b0;
		tick_ch.extra_disable  <= 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset values, no stop so no 1000-tick lockout gets loaded
		reg_read(REG_COOLDOWN);
		reg_read(REG_START_HOLD);
		send_tick(0, 0, 0, 0, 0);
		send_tick(0, 0, 0, 1, 0);   // external enable rising edge
		send_tick(0, 0, 0, 0, 0);
		drain();

		// directed: short cooldown and hold so every path shows up quickly
		set_regs(16'd3, 16'd4);
		send_tick(1, 0, 0, 0, 0);   // press while disabled loads hold timer
		repeat (4) send_tick(1, 0, 0, 0, 0);   // expiry requests enable
		send_tick(1, 0, 1, 0, 0);
		send_tick(0, 0, 1, 0, 0);   // release
		send_tick(1, 0, 1, 0, 0);   // press while enabled: stop + lockout
		send_tick(0, 1, 1, 0, 0);   // panic ignored during lockout
		send_tick(1, 0, 1, 1, 0);   // ext enable still acts in lockout
		send_tick(0, 0, 1, 0, 1);   // ext disable outranks
		send_tick(0, 0, 0, 0, 0);   // motion status falls: stop
		repeat (3) send_tick(0, 0, 0, 0, 0);
		send_tick(0, 1, 0, 0, 0);   // panic: stop
		repeat (3) send_tick(0, 0, 0, 0, 0);
		send_tick(1, 0, 0, 0, 0);
		send_tick(0, 0, 0, 0, 0);   // release cancels the hold timer
		send_tick(1, 0, 0, 1, 1);   // enable and stop together: stop wins
		send_tick(1, 1, 1, 1, 1);
		drain();

		// random phases; the max-lockout phase goes last since one stop
		// there locks the block for the rest of the run
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: begin cool = 16'd0; hold = 16'd0; end
				1: begin cool = 16'd0; hold = 16'd6; end
				2: begin cool = 16'd5; hold = 16'd0; end
				3: begin cool = 16'd3; hold = 16'hFFFF; end
				4: begin cool = 16'd1; hold = 16'd1; end
				8: begin cool = 16'hFFFF; hold = 16'hFFFF; end
				default: begin
					cool = CntW'($urandom_range(0, 12));
					hold = CntW'($urandom_range(1, 20));
				end
			endcase
			calm = (ph == 1 || ph == 6);
			set_regs(cool, hold);
			if (ph == 2 || ph == 7)
				squeeze_cnt++;
			random_phase(100, (hold > 40) ? 40 : hold);
			drain();
		end

		repeat (5) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
